// ===== design/lpac_pkg.sv =====
// Package for the lock-in PI controller: constants, CORDIC angle table, shared types.
// No dependencies.
package lpac_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam logic signed [31:0] DEG_90 = 32'sd5898240;
  localparam logic signed [31:0] DEG_180 = 32'sd11796480;
  localparam logic signed [31:0] DEG_360 = 32'sd23592960;
  localparam logic signed [31:0] HALF_VOLT = 32'sd32768;
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
  localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032875;
  localparam int SUM_BITS = 48;

  localparam logic [3:0] REG_PERIOD = 4'd0;
  localparam logic [3:0] REG_STEP = 4'd1;
  localparam logic [3:0] REG_VOLT = 4'd2;
  localparam logic [3:0] REG_PGAIN = 4'd3;
  localparam logic [3:0] REG_IGAIN = 4'd4;
  localparam logic [3:0] REG_ATOL = 4'd5;
  localparam logic [3:0] REG_PTOL = 4'd6;
  localparam logic [3:0] REG_INIT = 4'd7;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0: r = 32'sd2949120;
      5'd1: r = 32'sd1740967;
      5'd2: r = 32'sd919879;
      5'd3: r = 32'sd466945;
      5'd4: r = 32'sd234379;
      5'd5: r = 32'sd117304;
      5'd6: r = 32'sd58666;
      5'd7: r = 32'sd29335;
      5'd8: r = 32'sd14668;
      5'd9: r = 32'sd7334;
      5'd10: r = 32'sd3667;
      5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;
      5'd13: r = 32'sd458;
      5'd14: r = 32'sd229;
      5'd15: r = 32'sd115;
      5'd16: r = 32'sd57;
      5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;
      5'd19: r = 32'sd7;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // One queue entry: the sample and whether it closes a period.
  typedef struct packed {
    logic signed [15:0] smp;
    logic               last;
  } lpac_item_t;

endpackage

// ===== design/lockin_pi_amplitude_phase_control.sv =====
// Top level of the lock-in PI controller: configuration registers, front and back parts.
// Depends on lpac_pkg, lpac_front, lpac_back.
//
// channel   direction  handshake          payload
// sample    in         valid_in/stall_in  sample
// result    out        valid_out/stall_out drives, measurements, flags
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// In the back part a sample goes through queue pop, table read and accumulate.
// A period end adds 20 CORDIC iterations of one shared stage, split 32-bit multiplies
// for magnitude and volts, the PI update and the output load.
// A four-entry queue takes samples while the back part works or the result stalls.
// Reset is synchronous; all control state and integrals return to reset values.
module lockin_pi_amplitude_phase_control import lpac_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  output logic                          stall_in,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          valid_out,
  input  logic                          stall_out,
  output logic signed [31:0]            amplitude_drive,
  output logic signed [31:0]            phase_drive,
  output logic [30:0]                   measured_amplitude,
  output logic signed [24:0]            measured_phase,
  output logic                          drive_updated,
  output logic                          still_adjusting,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [3:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);

  logic [10:0] samples_per_period;
  logic [9:0] phase_step;
  logic [31:0] int_to_volt;
  logic [15:0] prop_gain, integral_gain, amplitude_tolerance;
  logic [24:0] phase_tolerance;
  logic cfg_we;
  logic q_valid, q_pop;
  lpac_item_t q_item;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_period <= 11'd1024; phase_step <= 10'd1; int_to_volt <= 32'd2745723;
      prop_gain <= 16'd819; integral_gain <= 16'd3277; amplitude_tolerance <= 16'd66;
      phase_tolerance <= 25'd131072;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD: samples_per_period <= cfg_data[10:0];
        REG_STEP: phase_step <= cfg_data[9:0];
        REG_VOLT: int_to_volt <= cfg_data;
        REG_PGAIN: prop_gain <= cfg_data[15:0];
        REG_IGAIN: integral_gain <= cfg_data[15:0];
        REG_ATOL: amplitude_tolerance <= cfg_data[15:0];
        REG_PTOL: phase_tolerance <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  lpac_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk(clk), .rst(rst), .valid_in(valid_in), .stall_in(stall_in), .sample(sample),
    .period(samples_per_period), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  lpac_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .phase_step(phase_step), .int_to_volt(int_to_volt), .prop_gain(prop_gain),
    .integral_gain(integral_gain), .amplitude_tolerance(amplitude_tolerance),
    .phase_tolerance(phase_tolerance),
    .init_load(cfg_we && cfg_index == REG_INIT), .init_value(cfg_data),
    .out_valid(valid_out), .out_stall(stall_out),
    .amplitude_drive(amplitude_drive), .phase_drive(phase_drive),
    .measured_amplitude(measured_amplitude), .measured_phase(measured_phase),
    .drive_updated(drive_updated), .still_adjusting(still_adjusting)
  );

`ifndef SYNTHESIS
  a_nodrive: assert property (@(posedge clk) disable iff (rst)
    valid_out && !drive_updated |-> amplitude_drive == 0 && phase_drive == 0)
    else $error("drives nonzero without update");
  a_adjust: assert property (@(posedge clk) disable iff (rst)
    valid_out && !drive_updated |-> !still_adjusting)
    else $error("adjusting flag kept after in-tolerance period");
  a_phase: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> $signed(measured_phase) <= 25'sd11796480 &&
                  $signed(measured_phase) >= -25'sd11796480)
    else $error("phase out of range");
`endif

endmodule

// ===== design/lpac_rom.sv =====
// Sine/cosine table, Q1.15, built at elaboration by a CORDIC rotation.
// Depends on lpac_pkg.
module lpac_rom import lpac_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int IDX_BITS = 10
) (
  input  logic                      clk,
  input  logic [IDX_BITS-1:0]       addr,
  output logic signed [15:0]        cos_q,
  output logic signed [15:0]        sin_q
);

  function automatic logic signed [63:0] asr64(input logic signed [63:0] v, input int n);
    return v >>> n;
  endfunction

  function automatic logic [31:0] build(input int k);
    logic signed [63:0] z, x, y, dx, dy, c, s;
    logic neg;
    z = (64'(k) * 64'(DEG_360)) / TABLE_DEPTH;
    x = 64'(INV_GAIN_Q30);
    y = 0;
    neg = 1'b0;
    if (z > 64'(DEG_90) && z <= 3 * 64'(DEG_90)) begin
      z = z - 64'(DEG_180);
      neg = 1'b1;
    end else if (z > 3 * 64'(DEG_90)) begin
      z = z - 64'(DEG_360);
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - 64'(atan_deg(5'(i)));
      end else begin
        x = x + dx; y = y - dy; z = z + 64'(atan_deg(5'(i)));
      end
    end
    c = (x + 16384) >>> 15;
    s = (y + 16384) >>> 15;
    if (c > 32767) c = 32767;
    if (c < -32767) c = -32767;
    if (s > 32767) s = 32767;
    if (s < -32767) s = -32767;
    if (neg) begin
      c = -c; s = -s;
    end
    return {c[15:0], s[15:0]};
  endfunction

  logic [31:0] tab [TABLE_DEPTH];
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_tab
    assign tab[k] = build(k);
  end

  always_ff @(posedge clk) begin
    cos_q <= tab[addr][31:16];
    sin_q <= tab[addr][15:0];
  end

endmodule

// ===== design/lpac_front.sv =====
// Front part: takes samples, counts the period and pushes items into a short queue.
// Depends on lpac_pkg.
module lpac_front import lpac_pkg::*; #(
  parameter int SAMPLE_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  output logic                          stall_in,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [10:0]                   period,
  output logic                          q_valid,
  output lpac_item_t                    q_item,
  input  logic                          q_pop
);

  localparam int QD = 4;
  lpac_item_t q [QD];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic [9:0] sample_count;
  logic [10:0] n;
  logic push;

  always_comb begin
    n = period;
    if (period < 11'd2) n = 11'd2;
    if (period > 11'd1024) n = 11'd1024;
  end

  assign stall_in = (cnt == 3'(QD));
  assign push = valid_in && !stall_in;
  assign q_valid = (cnt != 3'd0);
  assign q_item = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp].smp <= 16'(sample);
      q[wp].last <= ({1'b0, sample_count} + 11'd1 >= n);
    end
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; sample_count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 2'd1;
        sample_count <= ({1'b0, sample_count} + 11'd1 >= n) ? 10'd0 : sample_count + 10'd1;
      end
      if (q_pop) rp <= rp + 2'd1;
      cnt <= cnt + 3'(push) - 3'(q_pop);
    end
  end

endmodule

// ===== design/lpac_back.sv =====
// Back part: accumulate, vectoring CORDIC, scale, PI; one step a cycle unless held.
// Depends on lpac_pkg and lpac_rom.
module lpac_back import lpac_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  lpac_item_t         q_item,
  output logic               q_pop,
  input  logic [9:0]         phase_step,
  input  logic [31:0]        int_to_volt,
  input  logic [15:0]        prop_gain,
  input  logic [15:0]        integral_gain,
  input  logic [15:0]        amplitude_tolerance,
  input  logic [24:0]        phase_tolerance,
  input  logic               init_load,
  input  logic signed [31:0] init_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] amplitude_drive,
  output logic signed [31:0] phase_drive,
  output logic [30:0]        measured_amplitude,
  output logic signed [24:0] measured_phase,
  output logic               drive_updated,
  output logic               still_adjusting
);

  localparam int IB = $clog2(TABLE_DEPTH);
  localparam logic signed [47:0] SMAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SMIN = {1'b1, {47{1'b0}}};

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_ROM = 10'b0000000010, S_ACC = 10'b0000000100,
    S_PRE = 10'b0000001000, S_ROT = 10'b0000010000, S_MAG = 10'b0000100000,
    S_VOLT = 10'b0001000000, S_ERR = 10'b0010000000, S_PI = 10'b0100000000,
    S_OUT = 10'b1000000000
  } st_t;

  st_t state;
  logic [IB-1:0] table_index;
  logic signed [47:0] cos_sum, sin_sum;
  logic signed [15:0] smp;
  logic last;
  logic signed [15:0] rc, rs;
  logic signed [51:0] cx, cy;
  logic signed [31:0] cz;
  logic [4:0] it;
  logic [63:0] mag, volts;
  logic [1:0] ph;
  logic signed [33:0] e, ep;
  logic upd;
  logic signed [31:0] amplitude_integral, phase_integral;
  logic adjusting_flag;
  logic signed [49:0] pa, ia;
  logic signed [63:0] mhi, mlo;
  logic signed [31:0] amp_d, ph_d;

  lpac_rom #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_BITS(IB)) u_rom (
    .clk(clk), .addr(table_index), .cos_q(rc), .sin_q(rs)
  );

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'(SMAX)) return SMAX;
    if (v < 50'(SMIN)) return SMIN;
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [31:0] pr_a, pr_b;
  assign pr_a = 32'(signed'(rc)) * 32'(smp);
  assign pr_b = 32'(signed'(rs)) * 32'(smp);
  assign q_pop = (state == S_IDLE) && q_valid;

  logic signed [51:0] dxs, dys;
  assign dxs = cy >>> it;
  assign dys = cx >>> it;
  logic signed [33:0] ae, aep;
  assign ae = e < 0 ? -e : e;
  assign aep = ep < 0 ? -ep : ep;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (q_valid) begin
        smp <= q_item.smp;
        last <= q_item.last;
      end
      S_PRE: begin
        if (sin_sum < 0) begin
          cz <= (cos_sum >= 0) ? DEG_180 : -DEG_180;
          cx <= -52'(sin_sum); cy <= -52'(cos_sum);
        end else begin
          cz <= '0;
          cx <= 52'(sin_sum); cy <= 52'(cos_sum);
        end
        it <= '0;
      end
      S_ROT: begin
        if (cy >= 0) begin
          cx <= cx + dxs; cy <= cy - dys; cz <= cz + atan_deg(it);
        end else begin
          cx <= cx - dxs; cy <= cy + dys; cz <= cz - atan_deg(it);
        end
        it <= it + 5'd1;
      end
      S_MAG: begin
        // Magnitude and volts products split into a high part and a low 32-bit half over phases.
        if (ph == 2'd0) begin
          mhi <= 64'(cx[51:32]) * 64'(INV_GAIN_Q32);
          mlo <= 64'(cx[31:0]) * 64'(INV_GAIN_Q32);
        end else begin
          mag <= 64'(mhi) + 64'(mlo[63:32]);
        end
        if (cz > DEG_180) cz <= DEG_180;
        if (cz < -DEG_180) cz <= -DEG_180;
      end
      S_VOLT: begin
        if (ph == 2'd0) begin
          mhi <= 64'(mag[63:32]) * 64'(int_to_volt);
          mlo <= 64'(mag[31:0]) * 64'(int_to_volt);
        end else begin
          volts <= (64'(mhi) + 64'(mlo[63:32])) >> 7;
        end
      end
      S_ERR: begin
        if (sin_sum == 0 && cos_sum == 0) begin
          e <= 34'(HALF_VOLT); ep <= '0; cz <= '0; volts <= '0;
        end else begin
          if (volts > 64'h7fffffff) volts <= 64'h7fffffff;
          e <= 34'(HALF_VOLT) - (volts > 64'h7fffffff ? 34'sh7fffffff : 34'(volts));
          ep <= 34'(cz);
        end
      end
      S_PI: begin
        if (ph == 2'd0) begin
          upd <= (2 * ae > 34'(amplitude_tolerance)) || (aep > 34'(phase_tolerance));
          pa <= 50'(signed'({1'b0, prop_gain})) * 50'(e);
          ia <= 50'(signed'({1'b0, integral_gain})) * 50'(amplitude_integral);
        end else if (ph == 2'd1) begin
          amp_d <= upd ? sat32(64'(pa + ia) >>> 12) : '0;
          pa <= 50'(signed'({1'b0, prop_gain})) * 50'(ep);
          ia <= 50'(signed'({1'b0, integral_gain})) * 50'(phase_integral);
        end else begin
          ph_d <= upd ? sat32(64'(pa + ia) >>> 12) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; table_index <= '0; cos_sum <= '0; sin_sum <= '0;
      amplitude_integral <= 32'sd8192; phase_integral <= '0; adjusting_flag <= 1'b1;
      ph <= '0; out_valid <= 1'b0;
    end else begin
      if (init_load) amplitude_integral <= init_value;
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_valid) state <= S_ROM;
        S_ROM: state <= S_ACC;
        S_ACC: begin
          cos_sum <= sat48(50'(cos_sum) + 50'(pr_a));
          sin_sum <= sat48(50'(sin_sum) + 50'(pr_b));
          table_index <= table_index + IB'(phase_step);
          state <= last ? S_PRE : S_IDLE;
        end
        S_PRE: state <= S_ROT;
        S_ROT: if (it == 5'(CORDIC_STEPS - 1)) begin
          state <= S_MAG; ph <= '0;
        end
        S_MAG: begin
          ph <= ph + 2'd1;
          if (ph == 2'd1) begin
            state <= S_VOLT; ph <= '0;
          end
        end
        S_VOLT: begin
          ph <= ph + 2'd1;
          if (ph == 2'd1) begin
            state <= S_ERR; ph <= '0;
          end
        end
        S_ERR: state <= S_PI;
        S_PI: begin
          ph <= ph + 2'd1;
          if (ph == 2'd2) begin
            ph <= '0;
            if (upd) begin
              amplitude_integral <= sat32(64'(amplitude_integral) + 64'(e));
              phase_integral <= sat32(64'(phase_integral) + 64'(ep));
            end else begin
              adjusting_flag <= 1'b0;
            end
            state <= S_OUT;
          end
        end
        S_OUT: if (!out_valid || !out_stall) begin
          table_index <= '0; cos_sum <= '0; sin_sum <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The result registers load only when the previous request has left.
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      amplitude_drive <= amp_d;
      phase_drive <= ph_d;
      measured_amplitude <= volts[30:0];
      measured_phase <= cz[24:0];
      drive_updated <= upd;
      still_adjusting <= adjusting_flag;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for lockin_pi_amplitude_phase_control: samples, config writes, results.
// Depends on lpac_pkg (register indexes, constants); the tone table and CORDIC are rebuilt here.
module tb_top;
  import lpac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic signed [31:0] amp_drive;
    logic signed [31:0] ph_drive;
    logic [30:0]        volts;
    logic signed [24:0] phase;
    logic               updated;
    logic               adjusting;
  } lockin_result_t;

  logic clk, rst;
  logic valid_in, stall_in, valid_out, stall_out;
  logic signed [13:0] sample;
  logic signed [31:0] amplitude_drive, phase_drive;
  logic [30:0] measured_amplitude;
  logic signed [24:0] measured_phase;
  logic drive_updated, still_adjusting;
  logic cfg_valid, cfg_ready;
  logic [3:0] cfg_index;
  logic [31:0] cfg_data;

  lockin_pi_amplitude_phase_control uut (.*);

  // Predictor state: registers, accumulators and the sine/cosine table.
  int unsigned period_reg, step_reg, volt_scale, pgain, igain, atol, ptol;
  int init_integral;
  int unsigned count_q, index_q;
  longint cos_acc, sin_acc;
  int amp_integral, ph_integral;
  bit adjusting_q;
  int tone_cos[DEPTH], tone_sin[DEPTH];
  int angle_step[20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                         14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  lockin_result_t pending_results[$];
  int errors = 0, samples_sent = 0, results_seen = 0, updates_seen = 0, settled_seen = 0;
  int idle_cycles = 0;
  int long_stall_pct = 5;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void build_tone_table();
    longint z, x, y, dx, dy, c, s;
    bit neg;
    for (int k = 0; k < DEPTH; k++) begin
      z = (longint'(k) * DEG_360) / DEPTH;
      x = INV_GAIN_Q30;
      y = 0;
      neg = 0;
      if (z > DEG_90 && z <= 3 * longint'(DEG_90)) begin
        z -= DEG_180;
        neg = 1;
      end else if (z > 3 * longint'(DEG_90)) begin
        z -= DEG_360;
      end
      for (int i = 0; i < 20; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= angle_step[i];
        end else begin
          x += dx; y -= dy; z += angle_step[i];
        end
      end
      c = clip((x + 16384) >>> 15, -32767, 32767);
      s = clip((y + 16384) >>> 15, -32767, 32767);
      tone_cos[k] = neg ? -c : c;
      tone_sin[k] = neg ? -s : s;
    end
  endfunction

  function automatic void reset_predictor();
    period_reg = 1024; step_reg = 1; volt_scale = 2745723; pgain = 819; igain = 3277;
    atol = 66; ptol = 131072; init_integral = 8192;
    count_q = 0; index_q = 0; cos_acc = 0; sin_acc = 0;
    amp_integral = init_integral; ph_integral = 0; adjusting_q = 1;
  endfunction

  function automatic void apply_register(logic [3:0] idx, logic [31:0] data);
    case (idx)
      REG_PERIOD: period_reg = data[10:0];
      REG_STEP:   step_reg = data[9:0];
      REG_VOLT:   volt_scale = data;
      REG_PGAIN:  pgain = data[15:0];
      REG_IGAIN:  igain = data[15:0];
      REG_ATOL:   atol = data[15:0];
      REG_PTOL:   ptol = data[24:0];
      REG_INIT: begin
        init_integral = $signed(data);
        amp_integral = init_integral;
      end
      default: ;
    endcase
  endfunction

  // Accumulates one sample; at a period end returns 1 with the expected result.
  function automatic bit lockin_predict(logic signed [13:0] smp, output lockin_result_t r);
    longint x, y, z, dx, dy, e, ep, mag, volts, absn;
    logic [95:0] wide;
    int unsigned n;
    bit upd;
    n = period_reg < 2 ? 2 : (period_reg > 1024 ? 1024 : period_reg);
    cos_acc = clip(cos_acc + longint'(smp) * tone_cos[index_q], -(64'sd1 <<< 47),
                   (64'sd1 <<< 47) - 1);
    sin_acc = clip(sin_acc + longint'(smp) * tone_sin[index_q], -(64'sd1 <<< 47),
                   (64'sd1 <<< 47) - 1);
    index_q = (index_q + step_reg) % DEPTH;
    if (count_q + 1 < n) begin
      count_q++;
      return 0;
    end
    x = sin_acc; y = cos_acc; z = 0; volts = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        z = (y >= 0) ? DEG_180 : -longint'(DEG_180);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 20; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += angle_step[i];
        end else begin
          x -= dx; y += dy; z -= angle_step[i];
        end
      end
      z = clip(z, -longint'(DEG_180), DEG_180);
      wide = 96'(x) * 96'(INV_GAIN_Q32);
      mag = wide >> 32;
      wide = 96'(mag) * 96'(volt_scale);
      wide = wide >> 39;
      volts = (wide > 96'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(wide);
    end
    e = longint'(HALF_VOLT) - volts;
    ep = z;
    absn = e < 0 ? -e : e;
    upd = (2 * absn > atol) || ((ep < 0 ? -ep : ep) > ptol);
    r.amp_drive = 0;
    r.ph_drive = 0;
    if (upd) begin
      r.amp_drive = clip((longint'(pgain) * e + longint'(igain) * amp_integral) >>> 12,
                         -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      amp_integral = clip(longint'(amp_integral) + e, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      r.ph_drive = clip((longint'(pgain) * ep + longint'(igain) * ph_integral) >>> 12,
                        -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      ph_integral = clip(longint'(ph_integral) + ep, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    end else begin
      adjusting_q = 0;
    end
    count_q = 0; index_q = 0; cos_acc = 0; sin_acc = 0;
    r.volts = volts[30:0];
    r.phase = z[24:0];
    r.updated = upd;
    r.adjusting = adjusting_q;
    return 1;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall, mostly short bursts, occasionally long ones.
  initial begin
    int hold;
    stall_out = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < 50) begin
        stall_out <= 0;
        repeat ($urandom_range(20)) @(negedge clk);
      end else begin
        hold = ($urandom_range(99) < long_stall_pct) ? $urandom_range(300, 60)
                                                      : $urandom_range(4);
        stall_out <= 1;
        repeat (hold) @(negedge clk);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    lockin_result_t exp_r;
    if (!rst && valid_out && !stall_out) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result request");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        results_seen++;
        if (exp_r.updated) updates_seen++;
        if (!exp_r.adjusting) settled_seen++;
        if (amplitude_drive !== exp_r.amp_drive) begin
          $error("amplitude_drive expected %0d got %0d", exp_r.amp_drive, amplitude_drive);
          errors++;
        end
        if (phase_drive !== exp_r.ph_drive) begin
          $error("phase_drive expected %0d got %0d", exp_r.ph_drive, phase_drive);
          errors++;
        end
        if (measured_amplitude !== exp_r.volts) begin
          $error("measured_amplitude expected %0d got %0d", exp_r.volts, measured_amplitude);
          errors++;
        end
        if (measured_phase !== exp_r.phase) begin
          $error("measured_phase expected %0d got %0d", exp_r.phase, measured_phase);
          errors++;
        end
        if (drive_updated !== exp_r.updated) begin
          $error("drive_updated expected %0b got %0b", exp_r.updated, drive_updated);
          errors++;
        end
        if (still_adjusting !== exp_r.adjusting) begin
          $error("still_adjusting expected %0b got %0b", exp_r.adjusting, still_adjusting);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles where no channel moves a request.
  always @(posedge clk) begin
    if ((valid_in && !stall_in) || (valid_out && !stall_out) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [13:0] s);
    lockin_result_t r;
    int gap;
    gap = ($urandom_range(99) < 40) ? 0 :
          (($urandom_range(99) < 8) ? $urandom_range(150, 30) : $urandom_range(5, 1));
    if (gap > 0) begin
      @(negedge clk);
      valid_in <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    valid_in <= 1;
    sample <= s;
    @(posedge clk);
    while (stall_in) @(posedge clk);
    samples_sent++;
    if (lockin_predict(s, r)) pending_results.push_back(r);
  endtask

  // Stops sending until every expected result is in, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    valid_in <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [3:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // A tone at the table frequency with the given amplitude and phase offset, plus random noise.
  function automatic logic signed [13:0] tone_sample(int amp, int offset, int noise);
    longint v;
    v = (longint'(amp) * tone_sin[(index_q + offset) % DEPTH]) >>> 15;
    v += $signed($urandom_range(2 * noise)) - noise;
    return clip(v, -8192, 8191);
  endfunction

  function automatic logic signed [13:0] any_sample();
    case ($urandom_range(3))
      0: return 14'sh1FFF;
      1: return 14'sh2000;
      default: return $urandom();
    endcase
  endfunction

  // First half of a full-length period under the reset register values.
  task automatic test_reset_defaults();
    int amp;
    amp = $urandom_range(8191, 100);
    for (int i = 0; i < 512; i++) send_sample(tone_sample(amp, 0, 4));
    drain();
  endtask

  // The oversized period must still close after 1024 samples in total.
  task automatic test_period_clamp_high();
    write_register(REG_PERIOD, 11'h7FF);            // clamps down to 1024
    write_register(REG_STEP, 1);
    write_register(REG_VOLT, 2745723);
    for (int i = 0; i < 512; i++) send_sample(tone_sample(4000, 256, 0));
    drain();
  endtask

  task automatic test_extremes();
    write_register(REG_PERIOD, 2);
    write_register(REG_STEP, 512);
    write_register(REG_VOLT, 32'hFFFF_FFFF);
    write_register(REG_PGAIN, 16'hFFFF);
    write_register(REG_IGAIN, 16'hFFFF);
    write_register(REG_ATOL, 0);
    write_register(REG_PTOL, 0);
    write_register(REG_INIT, 32'h7FFF_FFFF);
    send_sample(14'sh1FFF); send_sample(14'sh2000);
    send_sample(14'sh2000); send_sample(14'sh1FFF);
    send_sample(0); send_sample(0);                 // zero vector
    send_sample(14'sh2000); send_sample(14'sh2000);
    drain();
    write_register(REG_INIT, 32'h8000_0000);
    write_register(REG_PERIOD, 0);                  // clamps up to two
    write_register(REG_STEP, 0);                    // index holds
    for (int i = 0; i < 4; i++) send_sample(any_sample());
    drain();
    write_register(REG_PERIOD, 1);
    write_register(REG_STEP, 1023);
    write_register(REG_ATOL, 16'hFFFF);
    write_register(REG_PTOL, DEG_360);
    write_register(REG_VOLT, 0);
    for (int i = 0; i < 4; i++) send_sample(any_sample());
    drain();
  endtask

  task automatic test_random_phases();
    int n, amp, offset, noise, len;
    for (int p = 0; p < 16; p++) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(128, 17) : $urandom_range(16, 2);
      long_stall_pct = $urandom_range(1) ? 0 : 8;
      write_register(REG_PERIOD, n);
      write_register(REG_STEP, $urandom_range(3) == 0 ? $urandom_range(1023) : DEPTH / n);
      write_register(REG_VOLT, $urandom_range(3) == 0 ? $urandom() : $urandom_range(4000000));
      write_register(REG_PGAIN, $urandom_range(65535));
      write_register(REG_IGAIN, $urandom_range(65535));
      write_register(REG_ATOL, $urandom_range(1) ? $urandom_range(65535) : $urandom_range(200));
      write_register(REG_PTOL, $urandom_range(1) ? $urandom_range(DEG_360)
                                                  : $urandom_range(DEG_180));
      if ($urandom_range(2) == 0) write_register(REG_INIT, $urandom());
      amp = $urandom_range(8191);
      offset = $urandom_range(1023);
      noise = $urandom_range(3) == 0 ? $urandom_range(2000) : $urandom_range(8);
      len = 0;
      while (len < 35) begin
        // Mostly tone samples; now and then raw noise or a stray extreme.
        if ($urandom_range(9) < 8) send_sample(tone_sample(amp, offset, noise));
        else send_sample(any_sample());
        len++;
        if ($urandom_range(199) == 0) drain();
      end
      drain();
    end
  endtask

  initial begin
    rst = 1;
    valid_in = 0;
    sample = 0;
    cfg_valid = 0;
    cfg_index = REG_PERIOD;
    cfg_data = 0;
    build_tone_table();
    reset_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_reset_defaults();
    test_period_clamp_high();
    test_extremes();
    test_random_phases();
    drain();
    $display("Sent %0d samples, checked %0d results (%0d drive updates, %0d settled).",
             samples_sent, results_seen, updates_seen, settled_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lpac_pkg.sv
design/lpac_rom.sv
design/lpac_front.sv
design/lpac_back.sv
design/lockin_pi_amplitude_phase_control.sv
bench/tb_top.sv
